>>> src/hcc_pkg.sv
// hcc_pkg: shared types, constants and codes for the hsv color class counter
// no dependencies; used by every module, the interfaces and the checker

package hcc_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned MAX_FRAME_PIXELS = 131072;
  localparam int unsigned CNT_W = 18;
  localparam int unsigned CNT_LIMIT = (1 << CNT_W) - 1;
  localparam int unsigned CNT_CAP_INT =
      (MAX_FRAME_PIXELS > CNT_LIMIT) ? CNT_LIMIT : MAX_FRAME_PIXELS;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

  localparam int unsigned DIV_STEPS = CH_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  localparam int unsigned HUE_W = 10;
  localparam logic [CH_W-1:0] HUE_OFF_R = 8'd0;
  localparam logic [CH_W-1:0] HUE_OFF_G = 8'd120;
  localparam logic [CH_W-1:0] HUE_OFF_B = 8'd240;
  localparam logic [HUE_W-1:0] HUE_WRAP = 10'd360;

  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned PROD_W = CNT_W + FACTOR_W;

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned REG_LSB = 3;
  localparam int unsigned REG_IDX_W = APB_ADDR_W - REG_LSB;

  localparam logic [47:0] RED_WIN_RST = 48'd55408109160960;
  localparam logic [31:0] GREEN_WIN_RST = 32'd1684295720;
  localparam logic [31:0] BLUE_WIN_RST = 32'd1684306020;
  localparam logic [31:0] PURPLE_WIN_RST = 32'd1684317555;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd500;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RED_WIN    = 3'd0,
    REG_GREEN_WIN  = 3'd1,
    REG_BLUE_WIN   = 3'd2,
    REG_PURPLE_WIN = 3'd3,
    REG_FACTOR     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    COL_RED    = 2'd0,
    COL_GREEN  = 2'd1,
    COL_BLUE   = 2'd2,
    COL_PURPLE = 2'd3
  } color_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SAT,
    ST_LOAD,
    ST_HUE,
    ST_CLASS,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [47:0]         red_window;
    logic [31:0]         green_window;
    logic [31:0]         blue_window;
    logic [31:0]         purple_window;
    logic [FACTOR_W-1:0] factor;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic load_hue;
    logic classify;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic zero_case;
    logic last_px;
    logic out_full;
  } sts_t;

  typedef struct packed {
    color_e           dom;
    logic [CNT_W-1:0] red;
    logic [CNT_W-1:0] green;
    logic [CNT_W-1:0] blue;
    logic [CNT_W-1:0] purple;
    logic [CNT_W-1:0] pixels;
  } res_t;

endpackage

>>> src/hcc_if.sv
// hcc_pix_if and hcc_res_if: valid/ready channels for pixels and frame results
// depends on hcc_pkg for field widths

interface hcc_pix_if;
  logic                       valid;
  logic                       ready;
  logic [hcc_pkg::CH_W-1:0]   red_in;
  logic [hcc_pkg::CH_W-1:0]   green_in;
  logic [hcc_pkg::CH_W-1:0]   blue_in;
  logic                       frame_end;

  modport source (output valid, red_in, green_in, blue_in, frame_end, input ready);
  modport sink (input valid, red_in, green_in, blue_in, frame_end, output ready);
endinterface

interface hcc_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  dominant_color;
  logic [hcc_pkg::CNT_W-1:0]   red_total;
  logic [hcc_pkg::CNT_W-1:0]   green_total;
  logic [hcc_pkg::CNT_W-1:0]   blue_total;
  logic [hcc_pkg::CNT_W-1:0]   purple_total;
  logic [hcc_pkg::CNT_W-1:0]   frame_pixels;

  modport source (output valid, dominant_color, red_total, green_total, blue_total,
                  purple_total, frame_pixels, input ready);
  modport sink (input valid, dominant_color, red_total, green_total, blue_total,
                purple_total, frame_pixels, output ready);
endinterface

>>> src/hcc_regs.sv
// hcc_regs: apb register file holding the color windows and purple factor
// depends on hcc_pkg

module hcc_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hcc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output hcc_pkg::cfg_t                      cfg_o
);

  hcc_pkg::cfg_t                     cfg_d, cfg_q;
  logic [hcc_pkg::REG_IDX_W-1:0]     idx;
  logic                              wr_en;

  assign idx    = paddr[hcc_pkg::APB_ADDR_W-1:hcc_pkg::REG_LSB];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        hcc_pkg::REG_RED_WIN:    cfg_d.red_window    = pwdata[47:0];
        hcc_pkg::REG_GREEN_WIN:  cfg_d.green_window  = pwdata[31:0];
        hcc_pkg::REG_BLUE_WIN:   cfg_d.blue_window   = pwdata[31:0];
        hcc_pkg::REG_PURPLE_WIN: cfg_d.purple_window = pwdata[31:0];
        hcc_pkg::REG_FACTOR:     cfg_d.factor        = pwdata[hcc_pkg::FACTOR_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hcc_pkg::REG_RED_WIN:    prdata = {16'h0, cfg_q.red_window};
      hcc_pkg::REG_GREEN_WIN:  prdata = {32'h0, cfg_q.green_window};
      hcc_pkg::REG_BLUE_WIN:   prdata = {32'h0, cfg_q.blue_window};
      hcc_pkg::REG_PURPLE_WIN: prdata = {32'h0, cfg_q.purple_window};
      hcc_pkg::REG_FACTOR:     prdata = {48'h0, cfg_q.factor};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_window    <= hcc_pkg::RED_WIN_RST;
      cfg_q.green_window  <= hcc_pkg::GREEN_WIN_RST;
      cfg_q.blue_window   <= hcc_pkg::BLUE_WIN_RST;
      cfg_q.purple_window <= hcc_pkg::PURPLE_WIN_RST;
      cfg_q.factor        <= hcc_pkg::FACTOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/hcc_ctrl.sv
// hcc_ctrl: state machine sequencing capture, the two divisions, counting and result
// depends on hcc_pkg

module hcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hcc_pkg::sts_t  sts_i,
  output hcc_pkg::cmd_t  cmd_o
);

  hcc_pkg::state_e                state_d, state_q;
  logic [hcc_pkg::STEP_W-1:0]     step_d, step_q;
  logic                           step_last;

  assign step_last = (step_q == hcc_pkg::STEP_W'(hcc_pkg::DIV_STEPS - 1));

  always_comb begin
    step_d = '0;
    if (state_q == hcc_pkg::ST_SAT || state_q == hcc_pkg::ST_HUE) begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hcc_pkg::ST_IDLE:   if (in_valid_i) state_d = hcc_pkg::ST_PREP;
      hcc_pkg::ST_PREP:   state_d = sts_i.zero_case ? hcc_pkg::ST_CLASS : hcc_pkg::ST_SAT;
      hcc_pkg::ST_SAT:    if (step_last) state_d = hcc_pkg::ST_LOAD;
      hcc_pkg::ST_LOAD:   state_d = hcc_pkg::ST_HUE;
      hcc_pkg::ST_HUE:    if (step_last) state_d = hcc_pkg::ST_CLASS;
      hcc_pkg::ST_CLASS:  state_d = sts_i.last_px ? hcc_pkg::ST_DECIDE : hcc_pkg::ST_IDLE;
      hcc_pkg::ST_DECIDE: state_d = hcc_pkg::ST_EMIT;
      hcc_pkg::ST_EMIT:   if (!sts_i.out_full) state_d = hcc_pkg::ST_IDLE;
      default:            state_d = hcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hcc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      hcc_pkg::ST_PREP:   cmd_o.prep = 1'b1;
      hcc_pkg::ST_SAT:    cmd_o.div_step = 1'b1;
      hcc_pkg::ST_LOAD:   cmd_o.load_hue = 1'b1;
      hcc_pkg::ST_HUE:    cmd_o.div_step = 1'b1;
      hcc_pkg::ST_CLASS:  cmd_o.classify = 1'b1;
      hcc_pkg::ST_DECIDE: cmd_o.decide = 1'b1;
      hcc_pkg::ST_EMIT:   cmd_o.emit = !sts_i.out_full;
      default:            cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcc_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> src/hcc_datapath.sv
// hcc_datapath: hsv conversion with a shared restoring divider, window match,
// saturating class counters, dominant color pick and the result register; uses hcc_pkg

module hcc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hcc_pkg::cfg_t               cfg_i,
  input  hcc_pkg::cmd_t               cmd_i,
  output hcc_pkg::sts_t               sts_o,
  input  logic [hcc_pkg::CH_W-1:0]    red_i,
  input  logic [hcc_pkg::CH_W-1:0]    green_i,
  input  logic [hcc_pkg::CH_W-1:0]    blue_i,
  input  logic                        last_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output hcc_pkg::res_t               res_o
);

  localparam int unsigned W = hcc_pkg::CH_W;
  localparam int unsigned CW = hcc_pkg::CNT_W;
  localparam int unsigned HW = hcc_pkg::HUE_W;

  function automatic logic win_hit(input logic [W-1:0] h, input logic [W-1:0] s,
                                   input logic [W-1:0] v, input logic [W-1:0] hmin,
                                   input logic [W-1:0] hmax, input logic [W-1:0] smin,
                                   input logic [W-1:0] vmin);
    return (h >= hmin) && (h <= hmax) && (s >= smin) && (v >= vmin);
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (x >= hcc_pkg::CNT_CAP) ? hcc_pkg::CNT_CAP : x + 1'b1;
  endfunction

  // captured pixel
  logic [W-1:0]  r_q, g_q, b_q;
  logic          last_q;

  // conversion front end
  logic [W-1:0]  mx, mn, dlt, mag;
  logic [W:0]    diff;
  logic [W-1:0]  off;
  logic [2*W-1:0] sat_num;
  logic [13:0]   hue_num;
  logic          zero;

  logic [W-1:0]  v_q, d_q, off_q, sat_q;
  logic [13:0]   hnum_q;
  logic          neg_q, zero_q;

  // divider
  logic [W-1:0]  rem_q, lo_q, div_q, quo_q;
  logic [W:0]    trial, trial_sub;
  logic          ge;

  // classification
  logic [HW-1:0] hsum, hfix;
  logic [W-1:0]  hue, sat;
  logic          hit_red, hit_green, hit_blue, hit_purple;

  // counters and decision
  logic [CW-1:0]                  red_cnt_q, green_cnt_q, blue_cnt_q, purple_cnt_q;
  logic [CW-1:0]                  pix_cnt_q;
  logic [hcc_pkg::PROD_W-1:0]     prod_q;
  hcc_pkg::color_e                dom_tree, dom_q, dom_fin;

  hcc_pkg::res_t                  res_q;
  logic                           out_valid_d, out_valid_q;

  always_comb begin
    mx = (r_q > g_q) ? ((r_q > b_q) ? r_q : b_q) : ((g_q > b_q) ? g_q : b_q);
    mn = (r_q < g_q) ? ((r_q < b_q) ? r_q : b_q) : ((g_q < b_q) ? g_q : b_q);
    dlt = mx - mn;
    zero = (mx == '0) || (dlt == '0);
    if (mx == r_q) begin
      diff = {1'b0, g_q} - {1'b0, b_q};
      off  = hcc_pkg::HUE_OFF_R;
    end else if (mx == g_q) begin
      diff = {1'b0, b_q} - {1'b0, r_q};
      off  = hcc_pkg::HUE_OFF_G;
    end else begin
      diff = {1'b0, r_q} - {1'b0, g_q};
      off  = hcc_pkg::HUE_OFF_B;
    end
    mag     = diff[W] ? W'(-diff) : diff[W-1:0];
    sat_num = {dlt, 8'h00} - {8'h00, dlt};
    hue_num = {mag, 6'b0} - {4'b0, mag, 2'b0};
  end

  // one quotient bit per cycle; dividend is always below 256 times the divisor
  assign trial     = {rem_q, lo_q[W-1]};
  assign ge        = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  always_comb begin
    hsum = {2'b0, off_q} + (neg_q ? (~{2'b0, quo_q} + 1'b1) : {2'b0, quo_q});
    hfix = hsum[HW-1] ? hsum + hcc_pkg::HUE_WRAP : hsum;
    hue  = zero_q ? '0 : hfix[W:1];
    sat  = zero_q ? '0 : sat_q;
    hit_red = win_hit(hue, sat, v_q, cfg_i.red_window[7:0], cfg_i.red_window[15:8],
                      cfg_i.red_window[39:32], cfg_i.red_window[47:40]) ||
              win_hit(hue, sat, v_q, cfg_i.red_window[23:16], cfg_i.red_window[31:24],
                      cfg_i.red_window[39:32], cfg_i.red_window[47:40]);
    hit_green = win_hit(hue, sat, v_q, cfg_i.green_window[7:0], cfg_i.green_window[15:8],
                        cfg_i.green_window[23:16], cfg_i.green_window[31:24]);
    hit_blue = win_hit(hue, sat, v_q, cfg_i.blue_window[7:0], cfg_i.blue_window[15:8],
                       cfg_i.blue_window[23:16], cfg_i.blue_window[31:24]);
    hit_purple = win_hit(hue, sat, v_q, cfg_i.purple_window[7:0],
                         cfg_i.purple_window[15:8], cfg_i.purple_window[23:16],
                         cfg_i.purple_window[31:24]);
  end

  always_comb begin
    if (red_cnt_q > blue_cnt_q) begin
      if (red_cnt_q > green_cnt_q) begin
        dom_tree = (red_cnt_q > purple_cnt_q) ? hcc_pkg::COL_RED : hcc_pkg::COL_PURPLE;
      end else begin
        dom_tree = (green_cnt_q > purple_cnt_q) ? hcc_pkg::COL_GREEN : hcc_pkg::COL_PURPLE;
      end
    end else begin
      if (blue_cnt_q > green_cnt_q) begin
        dom_tree = (blue_cnt_q > purple_cnt_q) ? hcc_pkg::COL_BLUE : hcc_pkg::COL_PURPLE;
      end else begin
        dom_tree = (green_cnt_q > purple_cnt_q) ? hcc_pkg::COL_GREEN : hcc_pkg::COL_PURPLE;
      end
    end
    dom_fin = (prod_q > {{hcc_pkg::FACTOR_W{1'b0}}, pix_cnt_q}) ? hcc_pkg::COL_PURPLE
                                                                 : dom_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r_q    <= red_i;
      g_q    <= green_i;
      b_q    <= blue_i;
      last_q <= last_i;
    end
    if (cmd_i.prep) begin
      v_q    <= mx;
      d_q    <= dlt;
      off_q  <= off;
      neg_q  <= diff[W];
      hnum_q <= hue_num;
      zero_q <= zero;
      rem_q  <= sat_num[2*W-1:W];
      lo_q   <= sat_num[W-1:0];
      div_q  <= mx;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? trial_sub[W-1:0] : trial[W-1:0];
      lo_q  <= {lo_q[W-2:0], 1'b0};
      quo_q <= {quo_q[W-2:0], ge};
    end
    if (cmd_i.load_hue) begin
      sat_q <= quo_q;
      rem_q <= {2'b0, hnum_q[13:W]};
      lo_q  <= hnum_q[W-1:0];
      div_q <= d_q;
    end
    if (cmd_i.decide) begin
      prod_q <= purple_cnt_q * cfg_i.factor;
      dom_q  <= dom_tree;
    end
    if (cmd_i.emit) begin
      res_q.dom    <= dom_fin;
      res_q.red    <= red_cnt_q;
      res_q.green  <= green_cnt_q;
      res_q.blue   <= blue_cnt_q;
      res_q.purple <= purple_cnt_q;
      res_q.pixels <= pix_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q    <= '0;
      green_cnt_q  <= '0;
      blue_cnt_q   <= '0;
      purple_cnt_q <= '0;
      pix_cnt_q    <= '0;
    end else if (cmd_i.emit) begin
      red_cnt_q    <= '0;
      green_cnt_q  <= '0;
      blue_cnt_q   <= '0;
      purple_cnt_q <= '0;
      pix_cnt_q    <= '0;
    end else if (cmd_i.classify) begin
      pix_cnt_q <= sat_inc(pix_cnt_q);
      if (hit_red) begin
        red_cnt_q <= sat_inc(red_cnt_q);
      end else if (hit_green) begin
        green_cnt_q <= sat_inc(green_cnt_q);
      end else if (hit_blue) begin
        blue_cnt_q <= sat_inc(blue_cnt_q);
      end else if (hit_purple) begin
        purple_cnt_q <= sat_inc(purple_cnt_q);
      end
    end
  end

  assign out_valid_d = cmd_i.emit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.zero_case = zero;
  assign sts_o.last_px   = last_q;
  assign sts_o.out_full  = out_valid_q & ~out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign res_o           = res_q;

endmodule

>>> src/hsv_color_class_counter.sv
// hsv_color_class_counter: top level, rgb pixels in, per-frame color class counts out
// one item at a time; colored pixels run through the shared 8-step restoring divider
// for saturation then hue, black or gray pixels skip it; frame-end pixels then go on
// to the dominant color pick, whose result is registered and held until taken
// rst_ni asynchronous active low: counters cleared, windows and factor to defaults
// depends on hcc_pkg, hcc_if, hcc_regs, hcc_ctrl and hcc_datapath

module hsv_color_class_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hcc_pix_if.sink                           pix_i,
  hcc_res_if.source                         res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hcc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hcc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hcc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  hcc_pkg::cfg_t  cfg;
  hcc_pkg::cmd_t  cmd;
  hcc_pkg::sts_t  sts;
  hcc_pkg::res_t  res;
  logic           in_ready;
  logic           out_valid;

  hcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hcc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .red_i       (pix_i.red_in),
    .green_i     (pix_i.green_in),
    .blue_i      (pix_i.blue_in),
    .last_i      (pix_i.frame_end),
    .out_ready_i (res_o.ready),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign pix_i.ready          = in_ready;
  assign res_o.valid          = out_valid;
  assign res_o.dominant_color = res.dom;
  assign res_o.red_total      = res.red;
  assign res_o.green_total    = res.green;
  assign res_o.blue_total     = res.blue;
  assign res_o.purple_total   = res.purple;
  assign res_o.frame_pixels   = res.pixels;

endmodule

>>> src/hcc_checker.sv
// hcc_checker: port-level assertions for the hsv color class counter, with its bind
// depends on hcc_pkg and the top level hsv_color_class_counter

module hcc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [1:0]                  dom_i,
  input logic [hcc_pkg::CNT_W-1:0]   red_i,
  input logic [hcc_pkg::CNT_W-1:0]   green_i,
  input logic [hcc_pkg::CNT_W-1:0]   blue_i,
  input logic [hcc_pkg::CNT_W-1:0]   purple_i,
  input logic [hcc_pkg::CNT_W-1:0]   pixels_i
);

  // one pixel in flight at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("pixel accepted while previous transaction still in work");

  a_class_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> red_i <= pixels_i && green_i <= pixels_i &&
                    blue_i <= pixels_i && purple_i <= pixels_i)
    else $error("class count above frame pixel total");

  a_nonempty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pixels_i != '0)
    else $error("result with empty frame");

  // a non-purple winner must beat purple outright
  a_winner_beats_purple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (dom_i == hcc_pkg::COL_PURPLE) ||
                    (dom_i == hcc_pkg::COL_RED && red_i > purple_i) ||
                    (dom_i == hcc_pkg::COL_GREEN && green_i > purple_i) ||
                    (dom_i == hcc_pkg::COL_BLUE && blue_i > purple_i))
    else $error("dominant color does not exceed purple count");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dom_i) && $stable(pixels_i) &&
                                    $stable(purple_i))
    else $error("stalled result transaction changed");

endmodule

bind hsv_color_class_counter hcc_checker u_hcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .dom_i       (res_o.dominant_color),
  .red_i       (res_o.red_total),
  .green_i     (res_o.green_total),
  .blue_i      (res_o.blue_total),
  .purple_i    (res_o.purple_total),
  .pixels_i    (res_o.frame_pixels)
);

>>> tb/hsv_color_class_counter_tb.sv
// hsv_color_class_counter_tb: self-checking bench for the hsv color class counter
// drives pixels and apb writes, predicts every frame result, checks it field by field
// depends on hcc_pkg, hcc_if and the hsv_color_class_counter rtl

`timescale 1ns / 1ps

module hsv_color_class_counter_tb;
  import hcc_pkg::*;

  localparam int unsigned SETTLE = 40;
  localparam int unsigned LIMIT = 4_000_000;
  localparam int unsigned DIR_N = 19;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam logic [REG_IDX_W-1:0] UNMAPPED_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  typedef struct packed {
    pixel_t px;
    logic   pinned;
    res_t   want;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } hsv_t;

  typedef enum {
    CFG_DEFAULT,
    CFG_RANDOM,
    CFG_OPEN_GREEN,
    CFG_INVERTED,
    CFG_FACTOR_ONE,
    CFG_FACTOR_MAX
  } setting_e;

  localparam int SEND_IDLE [4] = '{0, 54, 0, 38};
  localparam int RECV_STALL [4] = '{0, 0, 54, 38};
  localparam setting_e PHASE_SET [PHASES] = '{CFG_DEFAULT, CFG_RANDOM, CFG_OPEN_GREEN,
                                              CFG_INVERTED, CFG_RANDOM, CFG_FACTOR_ONE,
                                              CFG_FACTOR_MAX, CFG_RANDOM};

  // extremes and corner pixels; single-pixel frames carry their result inline
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1,
      '{COL_PURPLE, 18'd0, 18'd0, 18'd0, 18'd0, 18'd1}},
    '{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
      '{COL_PURPLE, 18'd0, 18'd0, 18'd0, 18'd0, 18'd1}},
    '{'{8'd255, 8'd0,   8'd0,   1'b1}, 1'b1,
      '{COL_RED,    18'd1, 18'd0, 18'd0, 18'd0, 18'd1}},
    '{'{8'd0,   8'd255, 8'd0,   1'b1}, 1'b1,
      '{COL_GREEN,  18'd0, 18'd1, 18'd0, 18'd0, 18'd1}},
    '{'{8'd0,   8'd0,   8'd255, 1'b1}, 1'b1,
      '{COL_BLUE,   18'd0, 18'd0, 18'd1, 18'd0, 18'd1}},
    '{'{8'd255, 8'd0,   8'd255, 1'b1}, 1'b1,
      '{COL_PURPLE, 18'd0, 18'd0, 18'd0, 18'd1, 18'd1}},
    '{'{8'd255, 8'd0,   8'd10,  1'b0}, 1'b0, '0},
    '{'{8'd200, 8'd100, 8'd50,  1'b0}, 1'b0, '0},
    '{'{8'd40,  8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd128, 8'd128, 8'd127, 1'b0}, 1'b0, '0},
    '{'{8'd1,   8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd1,   8'd2,   1'b0}, 1'b0, '0},
    '{'{8'd170, 8'd85,  8'd255, 1'b1}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd170, 8'd0,   8'd255, 1'b1}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  hcc_pix_if pix ();
  hcc_res_if res ();

  hsv_color_class_counter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t cfg;
  logic [CNT_W-1:0] class_cnt [4];
  logic [CNT_W-1:0] px_cnt;
  res_t frame_q [$];
  res_t want;

  int send_idle;
  int recv_stall;
  int unsigned errors;
  int unsigned cycles;
  int unsigned pixels_sent;
  int unsigned frames_sent;
  int unsigned frames_checked;
  int unsigned settings_used;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_error(input string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic hsv_t rgb_to_hsv(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    int ri, gi, bi, mx, mn, d, hue;
    hsv_t o;
    ri = r;
    gi = g;
    bi = b;
    mx = (ri > gi) ? ((ri > bi) ? ri : bi) : ((gi > bi) ? gi : bi);
    mn = (ri < gi) ? ((ri < bi) ? ri : bi) : ((gi < bi) ? gi : bi);
    d = mx - mn;
    o.v = 8'(mx);
    o.h = '0;
    o.s = '0;
    if (mx != 0 && d != 0) begin
      o.s = 8'((255 * d) / mx);
      if (mx == ri) hue = (60 * (gi - bi)) / d;
      else if (mx == gi) hue = 120 + (60 * (bi - ri)) / d;
      else hue = 240 + (60 * (ri - gi)) / d;
      if (hue < 0) hue += 360;
      o.h = 8'(hue / 2);
    end
    return o;
  endfunction

  // window bytes low to high: hue min, hue max, sat min, val min
  function automatic bit in_window(input hsv_t p, input logic [31:0] w);
    return p.h >= w[7:0] && p.h <= w[15:8] && p.s >= w[23:16] && p.v >= w[31:24];
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] x);
    return (x >= CNT_CAP) ? CNT_CAP : x + 1'b1;
  endfunction

  function automatic void tally_pixel(input pixel_t px, output bit done, output res_t fr);
    hsv_t p;
    logic [CNT_W-1:0] rc, gc, bc, pc;
    logic [PROD_W-1:0] prod;
    color_e dom;
    p = rgb_to_hsv(px.r, px.g, px.b);
    if (in_window(p, {cfg.red_window[47:32], cfg.red_window[15:0]}) ||
        in_window(p, {cfg.red_window[47:32], cfg.red_window[31:16]}))
      class_cnt[COL_RED] = bump(class_cnt[COL_RED]);
    else if (in_window(p, cfg.green_window))
      class_cnt[COL_GREEN] = bump(class_cnt[COL_GREEN]);
    else if (in_window(p, cfg.blue_window))
      class_cnt[COL_BLUE] = bump(class_cnt[COL_BLUE]);
    else if (in_window(p, cfg.purple_window))
      class_cnt[COL_PURPLE] = bump(class_cnt[COL_PURPLE]);
    px_cnt = bump(px_cnt);
    done = px.last;
    fr = '0;
    if (!px.last) return;
    rc = class_cnt[COL_RED];
    gc = class_cnt[COL_GREEN];
    bc = class_cnt[COL_BLUE];
    pc = class_cnt[COL_PURPLE];
    if (rc > bc) begin
      if (rc > gc) begin
        if (rc > pc) dom = COL_RED;
        else dom = COL_PURPLE;
      end else if (gc > pc) begin
        dom = COL_GREEN;
      end else begin
        dom = COL_PURPLE;
      end
    end else if (bc > gc) begin
      if (bc > pc) dom = COL_BLUE;
      else dom = COL_PURPLE;
    end else if (gc > pc) begin
      dom = COL_GREEN;
    end else begin
      dom = COL_PURPLE;
    end
    prod = PROD_W'(pc) * PROD_W'(cfg.factor);
    if (prod > PROD_W'(px_cnt)) dom = COL_PURPLE;
    fr.dom = dom;
    fr.red = rc;
    fr.green = gc;
    fr.blue = bc;
    fr.purple = pc;
    fr.pixels = px_cnt;
    foreach (class_cnt[i]) class_cnt[i] = '0;
    px_cnt = '0;
  endfunction

  function automatic logic [63:0] reg_shadow(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_RED_WIN: return 64'(cfg.red_window);
      REG_GREEN_WIN: return 64'(cfg.green_window);
      REG_BLUE_WIN: return 64'(cfg.blue_window);
      REG_PURPLE_WIN: return 64'(cfg.purple_window);
      REG_FACTOR: return 64'(cfg.factor);
      default: return '0;
    endcase
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, {REG_LSB{1'b0}}};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RED_WIN: cfg.red_window = val[47:0];
      REG_GREEN_WIN: cfg.green_window = val[31:0];
      REG_BLUE_WIN: cfg.blue_window = val[31:0];
      REG_PURPLE_WIN: cfg.purple_window = val[31:0];
      REG_FACTOR: cfg.factor = val[FACTOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    reg_idx_e idx;
    logic [63:0] got;
    idx = idx.first();
    repeat (idx.num()) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, {REG_LSB{1'b0}}};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== reg_shadow(idx))
        flag_error($sformatf("register %s reads %h, expected %h", idx.name(), got,
                             reg_shadow(idx)));
      @(posedge clk_i);
      idx = idx.next();
    end
  endtask

  function automatic logic [31:0] rand_window();
    logic [7:0] hmin, hmax;
    hmin = 8'($urandom_range(0, 179));
    hmax = 8'((hmin + $urandom_range(0, 60) > 255) ? 255 : hmin + $urandom_range(0, 60));
    return {8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)), hmax, hmin};
  endfunction

  task automatic apply_setting(input setting_e s);
    logic [31:0] w1, w2;
    settings_used++;
    case (s)
      CFG_DEFAULT: begin
        reg_write(REG_RED_WIN, 64'(RED_WIN_RST));
        reg_write(REG_GREEN_WIN, 64'(GREEN_WIN_RST));
        reg_write(REG_BLUE_WIN, 64'(BLUE_WIN_RST));
        reg_write(REG_PURPLE_WIN, 64'(PURPLE_WIN_RST));
        reg_write(REG_FACTOR, 64'(FACTOR_RST));
      end
      CFG_OPEN_GREEN: begin
        // red can never match, green takes everything
        reg_write(REG_RED_WIN, '1);
        reg_write(REG_GREEN_WIN, {32'hFFFF_FFFF, 32'h0000_FF00});
        reg_write(REG_BLUE_WIN, '0);
        reg_write(REG_PURPLE_WIN, '0);
        reg_write(REG_FACTOR, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      CFG_INVERTED: begin
        reg_write(REG_RED_WIN, {16'($urandom), 48'h0000_00FF_050A});
        reg_write(REG_GREEN_WIN, {$urandom, 32'h0000_2850});
        reg_write(REG_BLUE_WIN, {$urandom, rand_window()});
        reg_write(REG_PURPLE_WIN, {$urandom, rand_window()});
        reg_write(REG_FACTOR, '0);
      end
      CFG_FACTOR_MAX: begin
        reg_write(REG_RED_WIN, 64'(RED_WIN_RST));
        reg_write(REG_GREEN_WIN, 64'(GREEN_WIN_RST));
        reg_write(REG_BLUE_WIN, 64'(BLUE_WIN_RST));
        reg_write(REG_PURPLE_WIN, 64'(PURPLE_WIN_RST));
        reg_write(REG_FACTOR, {48'h0, 16'hFFFF});
      end
      default: begin
        w1 = rand_window();
        w2 = rand_window();
        reg_write(REG_RED_WIN, {16'($urandom), w1[31:16], w2[15:0], w1[15:0]});
        reg_write(REG_GREEN_WIN, {$urandom, rand_window()});
        reg_write(REG_BLUE_WIN, {$urandom, rand_window()});
        reg_write(REG_PURPLE_WIN, {$urandom, rand_window()});
        if (s == CFG_FACTOR_ONE) reg_write(REG_FACTOR, 64'd1);
        else reg_write(REG_FACTOR, {$urandom, 16'($urandom), 16'($urandom_range(1, 40))});
      end
    endcase
    check_regs();
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [7:0] m;
    px.last = 1'b0;
    case ($urandom_range(9))
      0, 1, 2: begin
        px.r = 8'($urandom);
        px.g = 8'($urandom);
        px.b = 8'($urandom);
      end
      3: begin
        m = ($urandom_range(3) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        px.r = m;
        px.g = m;
        px.b = m;
      end
      4: begin
        px.r = {8{1'($urandom_range(1))}};
        px.g = {8{1'($urandom_range(1))}};
        px.b = {8{1'($urandom_range(1))}};
      end
      default: begin
        // one leading channel, the others at or below it: spreads over the hue circle
        m = 8'($urandom_range(60, 255));
        px.r = 8'($urandom_range(0, m));
        px.g = 8'($urandom_range(0, m));
        px.b = 8'($urandom_range(0, m));
        case ($urandom_range(2))
          0: px.r = m;
          1: px.g = m;
          default: px.b = m;
        endcase
      end
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px, input bit pinned, input res_t pin_res);
    bit done;
    res_t fr;
    tally_pixel(px, done, fr);
    if (done) begin
      frame_q.push_back(pinned ? pin_res : fr);
      frames_sent++;
    end
    pixels_sent++;
    if ($urandom_range(99) < send_idle) begin
      pix.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    pix.valid <= 1'b1;
    pix.red_in <= px.r;
    pix.green_in <= px.g;
    pix.blue_in <= px.b;
    pix.frame_end <= px.last;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    send_idle = SEND_IDLE[mode];
    recv_stall = RECV_STALL[mode];
  endtask

  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d frame results outstanding", cycles,
               frame_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned exp);
    if (got != exp)
      flag_error($sformatf("frame %0d %s is %0d, expected %0d", frames_checked, name,
                           got, exp));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (frame_q.size() == 0) begin
        flag_error("frame result with no frame pending");
      end else begin
        want = frame_q.pop_front();
        compare_field("dominant_color", res.dominant_color, want.dom);
        compare_field("red_total", res.red_total, want.red);
        compare_field("green_total", res.green_total, want.green);
        compare_field("blue_total", res.blue_total, want.blue);
        compare_field("purple_total", res.purple_total, want.purple);
        compare_field("frame_pixels", res.frame_pixels, want.pixels);
        frames_checked++;
      end
    end
  end

  initial begin
    int left;
    pixel_t px;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix.valid = 1'b0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    pix.frame_end = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    cfg = '{RED_WIN_RST, GREEN_WIN_RST, BLUE_WIN_RST, PURPLE_WIN_RST, FACTOR_RST};
    foreach (class_cnt[i]) class_cnt[i] = '0;
    px_cnt = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, then writes outside the register map must change nothing
    check_regs();
    reg_write(UNMAPPED_LO, '1);
    reg_write(UNMAPPED_HI, '1);
    check_regs();

    set_idling(0);
    foreach (DIRECTED[i]) send_pixel(DIRECTED[i].px, DIRECTED[i].pinned, DIRECTED[i].want);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(PHASE_SET[ph]);
      set_idling(ph % 4);
      left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (left == 0) left = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 30);
        left--;
        px = random_pixel();
        px.last = (left == 0) || (n == ITEMS_PER_PHASE - 1);
        send_pixel(px, 1'b0, '0);
      end
      drain();
    end

    $display("sent %0d pixels in %0d frames under %0d register settings", pixels_sent,
             frames_sent, settings_used);
    $display("checked %0d frame results, %0d mismatches", frames_checked, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
